FILE: rtl/e2c_pkg.sv
// shared types and constants for the epoch seconds to calendar pipeline
// used by e2c_pipe_ctrl and epoch_seconds_to_calendar; no dependencies
`timescale 1ns / 1ps

package e2c_pkg;

	localparam int unsigned NUM_STAGES = 9;

	// reciprocals, rounded up, exact over each operand's full range
	localparam logic [25:0] RECIP_675      = 26'd50903317; // shift 35, 25-bit operand
	localparam logic [17:0] RECIP_60_SOD   = 18'd139811;   // shift 23, operand < 86400
	localparam logic [10:0] RECIP_60_MIN   = 11'd1093;     // shift 16, operand < 1440
	localparam logic [16:0] RECIP_7        = 17'd74899;    // shift 19
	localparam logic [15:0] RECIP_1461     = 16'd45934;    // shift 26
	localparam logic [10:0] RECIP_365      = 11'd1437;     // shift 19
	localparam logic [10:0] RECIP_153      = 11'd1714;     // shift 18

	// days from 1968-03-01 to 1970-01-01
	localparam logic [9:0]  EPOCH_MARCH_OFFSET = 10'd671;
	// day number of 2100-03-01 counted from 1968-03-01
	localparam logic [15:0] SKIPPED_LEAP_DAY   = 16'd48212;
	localparam logic [11:0] BASE_YEAR          = 12'd1968;
	// 1970-01-01 was a thursday
	localparam logic [2:0]  EPOCH_WEEKDAY      = 3'd4;

	typedef struct packed {
		logic [NUM_STAGES:1] en;  // stage load enables
		logic [NUM_STAGES:1] vld; // stage valid bits
	} pipe_ctrl_t;

	// first day of each month within a march-based year, month index 0 is march
	function automatic logic [8:0] month_start(input logic [3:0] mi);
		logic [8:0] r;
		case (mi)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/epoch_seconds_to_calendar.sv
// channel | dir | tdata fields, lowest bit first
// s_axis  | in  | epoch_seconds[31:0]
// m_axis  | out | cal_year[11:0] cal_month[15:12] day_of_month[20:16] weekday[23:21]
//         |     | hours[28:24] minutes[34:29] seconds[40:35] zero[47:41]
//
// nine register stages; a beat may enter every cycle unless all are full and m_axis stalls
// constant divides are reciprocal multiplies, at most two per stage, which sets the depth
// reset clears only the valid bits; payload registers are not reset
// each full stage holds while its successor is full and stalled, so empty stages
// still take beats while a result waits on m_axis
// top level: depends on e2c_pkg and e2c_pipe_ctrl
`timescale 1ns / 1ps

module epoch_seconds_to_calendar import e2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // epoch_seconds[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // year, month, day, weekday, hours, minutes, seconds, zero pad
);

	pipe_ctrl_t ctrl;

	e2c_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_ready(m_tready),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	// stage 1: seconds / 86400 as (seconds >> 7) / 675
	logic [24:0] x_in;
	logic [50:0] p675;
	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [15:0] days_s1;

	assign x_in = s_tdata[31:7];
	assign p675 = 51'(x_in) * 51'(RECIP_675);

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			x_s1    <= x_in;
			lo_s1   <= s_tdata[6:0];
			days_s1 <= p675[50:35];
		end
	end

	// stage 2: second of day
	logic [25:0] dmul;
	logic [25:0] rem_full;
	logic [15:0] days_s2;
	logic [16:0] sod_s2;

	assign dmul     = 26'(days_s1) * 26'd675;
	assign rem_full = 26'(x_s1) - dmul;

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			days_s2 <= days_s1;
			sod_s2  <= {rem_full[9:0], lo_s1};
		end
	end

	// stage 3: march-based day number, weekday quotient, minute of day
	logic [15:0] d_m;
	logic [15:0] dp;
	logic [15:0] wx;
	logic [32:0] wprod;
	logic [34:0] sprod;
	logic [15:0] dp_s3;
	logic [15:0] wx_s3;
	logic [12:0] wq_s3;
	logic [10:0] mt_s3;
	logic [16:0] sod_s3;

	assign d_m   = days_s2 + 16'(EPOCH_MARCH_OFFSET);
	// pretend 2100-02-29 exists so every fourth year stays a leap year
	assign dp    = d_m + 16'(d_m >= SKIPPED_LEAP_DAY);
	assign wx    = days_s2 + 16'(EPOCH_WEEKDAY);
	assign wprod = 33'(wx) * 33'(RECIP_7);
	assign sprod = 35'(sod_s2) * 35'(RECIP_60_SOD);

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			dp_s3  <= dp;
			wx_s3  <= wx;
			wq_s3  <= wprod[31:19];
			mt_s3  <= sprod[33:23];
			sod_s3 <= sod_s2;
		end
	end

	// stage 4: seconds, weekday, hour quotient, four-year cycle
	logic [16:0] sec_full;
	logic [21:0] hprod;
	logic [15:0] wd_full;
	logic [31:0] qprod;
	logic [5:0]  sec_s4;
	logic [4:0]  hq_s4;
	logic [10:0] mt_s4;
	logic [2:0]  wd_s4;
	logic [5:0]  quad_s4;
	logic [15:0] dp_s4;

	assign sec_full = sod_s3 - 17'(mt_s3) * 17'd60;
	assign hprod    = 22'(mt_s3) * 22'(RECIP_60_MIN);
	assign wd_full  = wx_s3 - 16'(wq_s3) * 16'd7;
	assign qprod    = 32'(dp_s3) * 32'(RECIP_1461);

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			sec_s4  <= sec_full[5:0];
			hq_s4   <= hprod[20:16];
			mt_s4   <= mt_s3;
			wd_s4   <= wd_full[2:0];
			quad_s4 <= qprod[31:26];
			dp_s4   <= dp_s3;
		end
	end

	// stage 5: minutes, day within the four-year cycle
	logic [10:0] min_full;
	logic [15:0] r_full;
	logic [5:0]  sec_s5;
	logic [4:0]  hours_s5;
	logic [5:0]  min_s5;
	logic [2:0]  wd_s5;
	logic [5:0]  quad_s5;
	logic [10:0] r_s5;

	assign min_full = mt_s4 - 11'(hq_s4) * 11'd60;
	assign r_full   = dp_s4 - 16'(quad_s4) * 16'd1461;

	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			sec_s5   <= sec_s4;
			hours_s5 <= hq_s4;
			min_s5   <= min_full[5:0];
			wd_s5    <= wd_s4;
			quad_s5  <= quad_s4;
			r_s5     <= r_full[10:0];
		end
	end

	// stage 6: year within the cycle, the last day of a leap cycle stays in year three
	logic [21:0] yprod;
	logic [1:0]  yoq;
	logic [5:0]  sec_s6;
	logic [4:0]  hours_s6;
	logic [5:0]  min_s6;
	logic [2:0]  wd_s6;
	logic [5:0]  quad_s6;
	logic [10:0] r_s6;
	logic [1:0]  yoq_s6;

	assign yprod = 22'(r_s5) * 22'(RECIP_365);
	assign yoq   = yprod[21] ? 2'd3 : yprod[20:19];

	always_ff @(posedge clk) begin
		if (ctrl.en[6]) begin
			sec_s6   <= sec_s5;
			hours_s6 <= hours_s5;
			min_s6   <= min_s5;
			wd_s6    <= wd_s5;
			quad_s6  <= quad_s5;
			r_s6     <= r_s5;
			yoq_s6   <= yoq;
		end
	end

	// stage 7: day of the march-based year and the march-based year itself
	logic [10:0] doy_full;
	logic [5:0]  sec_s7;
	logic [4:0]  hours_s7;
	logic [5:0]  min_s7;
	logic [2:0]  wd_s7;
	logic [8:0]  doy_s7;
	logic [11:0] year_s7;

	assign doy_full = r_s6 - 11'(yoq_s6) * 11'd365;

	always_ff @(posedge clk) begin
		if (ctrl.en[7]) begin
			sec_s7   <= sec_s6;
			hours_s7 <= hours_s6;
			min_s7   <= min_s6;
			wd_s7    <= wd_s6;
			doy_s7   <= doy_full[8:0];
			year_s7  <= BASE_YEAR + 12'({quad_s6, 2'b00}) + 12'(yoq_s6);
		end
	end

	// stage 8: month index, march is zero
	logic [10:0] mnum;
	logic [21:0] mprod;
	logic [5:0]  sec_s8;
	logic [4:0]  hours_s8;
	logic [5:0]  min_s8;
	logic [2:0]  wd_s8;
	logic [8:0]  doy_s8;
	logic [11:0] year_s8;
	logic [3:0]  mi_s8;

	assign mnum  = 11'(doy_s7) * 11'd5 + 11'd2;
	assign mprod = 22'(mnum) * 22'(RECIP_153);

	always_ff @(posedge clk) begin
		if (ctrl.en[8]) begin
			sec_s8   <= sec_s7;
			hours_s8 <= hours_s7;
			min_s8   <= min_s7;
			wd_s8    <= wd_s7;
			doy_s8   <= doy_s7;
			year_s8  <= year_s7;
			mi_s8    <= mprod[21:18];
		end
	end

	// stage 9: output register, january and february belong to the next year
	logic        wrap;
	logic [8:0]  day_full;
	logic [11:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9;
	logic [2:0]  wd_s9;
	logic [4:0]  hours_s9;
	logic [5:0]  min_s9;
	logic [5:0]  sec_s9;

	assign wrap     = mi_s8 >= 4'd10;
	assign day_full = doy_s8 - month_start(mi_s8) + 9'd1;

	always_ff @(posedge clk) begin
		if (ctrl.en[9]) begin
			year_s9  <= year_s8 + 12'(wrap);
			month_s9 <= wrap ? (mi_s8 - 4'd9) : (mi_s8 + 4'd3);
			day_s9   <= day_full[4:0];
			wd_s9    <= wd_s8;
			hours_s9 <= hours_s8;
			min_s9   <= min_s8;
			sec_s9   <= sec_s8;
		end
	end

	assign m_tvalid = ctrl.vld[NUM_STAGES];
	assign m_tdata  = {7'd0, sec_s9, min_s9, hours_s9, wd_s9, day_s9, month_s9, year_s9};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (month_s9 >= 4'd1 && month_s9 <= 4'd12 && day_s9 >= 5'd1))
		else $error("month or day out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (year_s9 >= 12'd1970 && year_s9 <= 12'd2106))
		else $error("year out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hours_s9 <= 5'd23 && min_s9 <= 6'd59 && sec_s9 <= 6'd59
			&& wd_s9 <= 3'd6))
		else $error("time of day or weekday out of range");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[7] |-> doy_s7 <= 9'd365)
		else $error("day of year out of range");

endmodule

FILE: rtl/e2c_pipe_ctrl.sv
// valid and load enable chain for the calendar pipeline
// depends on e2c_pkg for the stage count and the control struct
`timescale 1ns / 1ps

module e2c_pipe_ctrl import e2c_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output logic       in_ready,
	output pipe_ctrl_t ctrl
);

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] en;

	// a stage loads when it is empty or the stage after it moves on
	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i - 1];
				end
			end
		end
	end

	assign in_ready = en[1];
	assign ctrl.en  = en;
	assign ctrl.vld = vld_q;

endmodule
